// ===== src/received_chunk_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// received chunk tracker assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RECEIVED_CHUNK_TRACKER_DEFINES_SVH
`define RECEIVED_CHUNK_TRACKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RCT_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// shared constants, codes and types of the received chunk tracker
// ----------------------------------------------------------------------------
package rct_pkg;

   // map size default
   localparam int MAP_ENTRIES_DEF = 16384;

   // chunk payload sizes
   localparam int PAY_NEW   = 1440;
   localparam int PAY_OLD   = 1024;
   localparam int PAY_W     = 11;
   localparam int OLD_SHIFT = 10;

   // transfer limits
   localparam int SIZE_CAP = 16777216;
   localparam int TOTAL_W  = 25;

   // map memory row layout
   localparam int ROW_BITS  = 32;
   localparam int ROW_SHIFT = 5;

   // operation codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_CHUNK = 2'd1;
   localparam logic [1:0] OP_DONE  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TOO_BIG = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;

   // first stop position within one map row
   typedef struct packed {
      logic                 found;
      logic [ROW_SHIFT-1:0] pos;
   } find_type;

endpackage

// ===== src/rct_div.sv =====
// ----------------------------------------------------------------------------
// rct_div
// registered divide by the chunk payload: shift for 1024, reciprocal for 1440
// ----------------------------------------------------------------------------
module rct_div #(
   parameter int DIV_W = 27
) (
   input  logic                                 clock,
   input  logic                                 legacy,
   input  logic [DIV_W-1:0]                     dividend,
   output logic [DIV_W-rct_pkg::OLD_SHIFT-1:0]  quotient
);
   import rct_pkg::*;

   localparam int Q_W = DIV_W - OLD_SHIFT;
   localparam int K   = DIV_W + PAY_W;
   localparam int M_W = K - OLD_SHIFT;
   localparam int P_W = DIV_W + M_W;
   // exact for every dividend below 2**DIV_W since the rounding error stays under 2**PAY_W
   localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << K) + 64'(PAY_NEW - 1)) / 64'(PAY_NEW));

   logic [P_W-1:0]       prod;
   logic [Q_W-1:0]       quotient_in;
   logic [Q_W-1:0]       quotient_ff;

   assign prod = P_W'(dividend) * P_W'(RECIP);

   always_comb begin
      if (legacy) begin
         quotient_in = Q_W'(dividend >> OLD_SHIFT);
      end else begin
         quotient_in = Q_W'(prod >> K);
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
   end

   assign quotient = quotient_ff;

endmodule

// ===== src/rct_find.sv =====
// ----------------------------------------------------------------------------
// rct_find
// first missing or out-of-range entry within one 32-entry map row
// ----------------------------------------------------------------------------
module rct_find #(
   parameter int ROW_W = 9,
   parameter int CNT_W = 15
) (
   input  logic [rct_pkg::ROW_BITS-1:0] row_data,
   input  logic [ROW_W-1:0]             row,
   input  logic [CNT_W-1:0]             lim,
   output rct_pkg::find_type            hit
);
   import rct_pkg::*;

   logic [CNT_W-1:0]    row_base;
   logic [CNT_W-1:0]    rem;
   logic [ROW_BITS-1:0] in_range;
   logic [ROW_BITS-1:0] stop;

   assign row_base = CNT_W'({row, {ROW_SHIFT{1'b0}}});
   // row_base never passes lim while scanning
   assign rem      = lim - row_base;

   always_comb begin
      for (int p = 0; p < ROW_BITS; p++) begin
         in_range[p] = (rem > CNT_W'(p));
      end
   end

   // stop at an entry not yet seen or at the end of the expected range
   assign stop = ~row_data | ~in_range;

   always_comb begin
      hit.found = |stop;
      hit.pos   = '0;
      for (int p = ROW_BITS - 1; p >= 0; p--) begin
         if (stop[p]) begin
            hit.pos = ROW_SHIFT'(p);
         end
      end
   end

endmodule

// ===== src/received_chunk_tracker.sv =====
// ----------------------------------------------------------------------------
// received_chunk_tracker
// receive map of one chunked memory transfer, kept in a bit memory of rows
// ----------------------------------------------------------------------------
// start, unused op or out-of-range chunk gives its result in the cycle after the transfer
// an in-limit start then clears all ROWS rows (512 at 16384 entries) one row a cycle, busy high
// chunk: divide, map row read, then map row write; busy holds the next request off meanwhile
// done query: divide, fetch row 0, scan 1..ROWS map rows to the first missing entry, offset, result
// reset: synchronous; base, size and mode clear, then a clearing pass over the map with busy high
// results come on a one-cycle strobe and the receiver cannot stall them
// ----------------------------------------------------------------------------
`include "received_chunk_tracker_defines.svh"

module received_chunk_tracker #(
   parameter int MAP_ENTRIES = rct_pkg::MAP_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_operation,
   input  logic [31:0]               req_address,
   input  logic [31:0]               req_transfer_size,
   // mode register
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data,
   // response channel
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic                      rsp_cacheable_dest,
   output logic                      rsp_complete,
   output logic [31:0]               rsp_missing_address,
   output logic [rct_pkg::PAY_W-1:0] rsp_missing_size
);
   import rct_pkg::*;

   // map geometry
   localparam int ROWS  = (MAP_ENTRIES + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int IDX_W = $clog2(MAP_ENTRIES);
   localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
   // divider width covers in-map chunk offsets and the rounded-up total size
   localparam int OFF_W = $clog2(MAP_ENTRIES * PAY_NEW);
   localparam int DIV_W = (OFF_W > TOTAL_W) ? OFF_W : TOTAL_W;
   localparam int Q_W   = DIV_W - OLD_SHIFT;

   // byte limits
   localparam logic [31:0] SIZE_LIMIT = 32'(SIZE_CAP);
   localparam logic [31:0] RANGE_NEW  = 32'(MAP_ENTRIES * PAY_NEW);
   localparam logic [31:0] RANGE_OLD  = 32'(MAP_ENTRIES * PAY_OLD);

   // uncached address regions
   localparam logic [2:0] REGION_UC_A = 3'h5;
   localparam logic [2:0] REGION_UC_B = 3'h7;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CLEAR = 8'b0000_0010,
      S_CIDX  = 8'b0000_0100,
      S_CWR   = 8'b0000_1000,
      S_NEED  = 8'b0001_0000,
      S_SCAN  = 8'b0010_0000,
      S_OFF   = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   // control state
   state_type             state_ff, state_in;
   logic                  legacy_ff, legacy_in;
   logic [31:0]           base_ff, base_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [ROW_SHIFT-1:0]  bit_ff, bit_in;
   logic [Q_W-1:0]        need_ff, need_in;
   logic [CNT_W-1:0]      lim_ff, lim_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [31:0]           off_ff, off_in;

   // response registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_cache_ff, rsp_cache_in;
   logic                  rsp_complete_ff, rsp_complete_in;
   logic [31:0]           rsp_addr_ff, rsp_addr_in;
   logic [PAY_W-1:0]      rsp_size_ff, rsp_size_in;

   // map memory, one read and one write port, registered read
   logic [ROW_BITS-1:0]   map_mem [ROWS];
   logic [ROW_BITS-1:0]   rd_data_ff;
   logic                  mem_we;
   logic [ROW_W-1:0]      mem_wr_row;
   logic [ROW_BITS-1:0]   mem_wd;
   logic                  mem_re;
   logic [ROW_W-1:0]      mem_rd_row;

   // datapath
   logic                  accept;
   logic [PAY_W-1:0]      pay_sel;
   logic [31:0]           offset;
   logic                  too_big;
   logic [DIV_W-1:0]      div_x;
   logic [Q_W-1:0]        quotient;
   logic [IDX_W-1:0]      chunk_idx;
   find_type              hit;
   logic [CNT_W+PAY_W-1:0] off_prod;
   logic [TOTAL_W-1:0]    left;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign pay_sel = legacy_ff ? PAY_W'(PAY_OLD) : PAY_W'(PAY_NEW);

   // chunk offset wraps, so an address just below base lands out of range, while a transfer may wrap
   assign offset  = req_address - base_ff;
   assign too_big = (req_transfer_size > SIZE_LIMIT) ||
                    (legacy_ff && (req_transfer_size > RANGE_OLD));

   // one divider serves chunk index and expected chunk count
   always_comb begin
      if (req_operation == OP_CHUNK) begin
         div_x = offset[DIV_W-1:0];
      end else begin
         div_x = DIV_W'(total_ff) + DIV_W'(pay_sel - PAY_W'(1));
      end
   end

   rct_div #(
      .DIV_W    (DIV_W)
   ) u_div (
      .clock    (clock),
      .legacy   (legacy_ff),
      .dividend (div_x),
      .quotient (quotient)
   );

   assign chunk_idx = quotient[IDX_W-1:0];

   rct_find #(
      .ROW_W    (ROW_W),
      .CNT_W    (CNT_W)
   ) u_find (
      .row_data (rd_data_ff),
      .row      (row_ff),
      .lim      (lim_ff),
      .hit      (hit)
   );

   assign off_prod = (CNT_W+PAY_W)'(idx_ff) * (CNT_W+PAY_W)'(pay_sel);
   assign left     = total_ff - off_ff[TOTAL_W-1:0];

   always_comb begin
      state_in        = state_ff;
      legacy_in       = legacy_ff;
      base_in         = base_ff;
      total_in        = total_ff;
      row_in          = row_ff;
      bit_in          = bit_ff;
      need_in         = need_ff;
      lim_in          = lim_ff;
      idx_in          = idx_ff;
      off_in          = off_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = ST_OK;
      rsp_cache_in    = 1'b0;
      rsp_complete_in = 1'b0;
      rsp_addr_in     = '0;
      rsp_size_in     = '0;
      mem_we          = 1'b0;
      mem_wr_row      = row_ff;
      mem_wd          = '0;
      mem_re          = 1'b0;
      mem_rd_row      = row_ff;

      // the user must write the mode register only while idle; the block itself does not enforce it
      if (csr_write_enable) begin
         legacy_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_START: begin
                     rsp_strobe_in = 1'b1;
                     if (too_big) begin
                        // rejected start keeps base, size and map
                        rsp_status_in = ST_TOO_BIG;
                     end else begin
                        base_in      = req_address;
                        total_in     = TOTAL_W'(req_transfer_size);
                        rsp_cache_in = (req_address[31:29] != REGION_UC_A) &&
                                       (req_address[31:29] != REGION_UC_B);
                        row_in       = '0;
                        state_in     = S_CLEAR;
                     end
                  end
                  OP_CHUNK: begin
                     if (offset >= (legacy_ff ? RANGE_OLD : RANGE_NEW)) begin
                        // index past the map: flag, mark nothing
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        state_in = S_CIDX;
                     end
                  end
                  OP_DONE: begin
                     state_in = S_NEED;
                  end
                  default: begin
                     // unused op: all-zero result
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_wr_row = row_ff;
            mem_wd     = '0;
            if (row_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_CIDX: begin
            // quotient holds the chunk index, fetch its row
            mem_re     = 1'b1;
            mem_rd_row = ROW_W'(chunk_idx >> ROW_SHIFT);
            row_in     = ROW_W'(chunk_idx >> ROW_SHIFT);
            bit_in     = chunk_idx[ROW_SHIFT-1:0];
            state_in   = S_CWR;
         end
         S_CWR: begin
            // read-modify-write; only one item is in flight, so no forwarding
            mem_we        = 1'b1;
            mem_wr_row    = row_ff;
            mem_wd        = rd_data_ff | (ROW_BITS'(1) << bit_ff);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_NEED: begin
            // expected count ready, clamp the scan to the map and fetch row 0
            need_in = quotient;
            if (quotient < Q_W'(MAP_ENTRIES)) begin
               lim_in = CNT_W'(quotient);
            end else begin
               lim_in = CNT_W'(MAP_ENTRIES);
            end
            mem_re     = 1'b1;
            mem_rd_row = '0;
            row_in     = '0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (hit.found) begin
               idx_in   = CNT_W'({row_ff, {ROW_SHIFT{1'b0}}}) + CNT_W'(hit.pos);
               state_in = S_OFF;
            end else if (row_ff == ROW_W'(ROWS - 1)) begin
               // every map entry seen: the scan ends at the map end
               idx_in   = lim_ff;
               state_in = S_OFF;
            end else begin
               mem_re     = 1'b1;
               mem_rd_row = row_ff + ROW_W'(1);
               row_in     = row_ff + ROW_W'(1);
            end
         end
         S_OFF: begin
            off_in   = 32'(off_prod);
            state_in = S_FIN;
         end
         S_FIN: begin
            rsp_strobe_in = 1'b1;
            if (Q_W'(idx_ff) == need_ff) begin
               rsp_complete_in = 1'b1;
            end else begin
               rsp_addr_in = base_ff + off_ff;
               if (left < TOTAL_W'(pay_sel)) begin
                  rsp_size_in = left[PAY_W-1:0];
               end else begin
                  rsp_size_in = pay_sel;
               end
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         legacy_ff     <= 1'b0;
         base_ff       <= '0;
         total_ff      <= '0;
         row_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         legacy_ff     <= legacy_in;
         base_ff       <= base_in;
         total_ff      <= total_in;
         row_ff        <= row_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      bit_ff          <= bit_in;
      need_ff         <= need_in;
      lim_ff          <= lim_in;
      idx_ff          <= idx_in;
      off_ff          <= off_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_cache_ff    <= rsp_cache_in;
      rsp_complete_ff <= rsp_complete_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_size_ff     <= rsp_size_in;
   end

   // map memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wr_row] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_rd_row];
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_cacheable_dest  = rsp_cache_ff;
   assign rsp_complete        = rsp_complete_ff;
   assign rsp_missing_address = rsp_addr_ff;
   assign rsp_missing_size    = rsp_size_ff;

   // checks
   `RCT_ASSERT_NEXT(a_quick_rsp, accept && (req_operation == OP_START || req_operation == OP_NONE), rsp_strobe, "start or unused op gave no result in the next cycle")
   `RCT_ASSERT_NOW(a_map_ports, mem_we, !mem_re, "map row read and written in the same cycle")
   `RCT_ASSERT_NOW(a_complete_zero, rsp_strobe && rsp_complete, rsp_missing_size == '0 && rsp_missing_address == '0 && rsp_status == ST_OK, "complete result carries a missing chunk")
   `RCT_ASSERT_NOW(a_size_bound, rsp_strobe, rsp_missing_size <= PAY_W'(PAY_NEW), "missing size above the payload")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the received chunk tracker: a directed table, then
// random transfers in both payload modes, every report checked in order
// ----------------------------------------------------------------------------
module tb_top;
   import rct_pkg::*;

   localparam int ENTRIES     = MAP_ENTRIES_DEF;
   localparam int STALL_LIMIT = 5000;   // longer than the clearing pass and the longest done scan
   localparam int PHASE_ITEMS = 210;    // six random phases, about 1250 requests in all
   localparam int TAIL_CYCLES = 600;    // longer than the slowest operation
   localparam int DIR_ROWS    = 25;

   // regions that are never cached
   localparam logic [2:0] NOCACHE_RGN_LO = 3'd5;
   localparam logic [2:0] NOCACHE_RGN_HI = 3'd7;

   // base address of the size-limit starts and of the first chunked directed transfer
   localparam logic [31:0] BASE = 32'h1000_0000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] addr;
      logic [31:0] size;
   } chunk_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             cacheable;
      logic             complete;
      logic [31:0]      miss_addr;
      logic [PAY_W-1:0] miss_size;
   } chunk_rsp_type;

   // one directed row: request, and a hand-written report where typed is set
   typedef struct packed {
      chunk_req_type req;
      logic          typed;
      chunk_rsp_type rsp;
   } dir_row_type;

   // ------------------------------------------------------------------------
   // clock, reset, block ports
   // ------------------------------------------------------------------------
   logic                clock               = 1'b0;
   logic                reset               = 1'b1;
   logic                start               = 1'b0;
   logic                busy;
   logic [1:0]          req_operation       = OP_NONE;
   logic [31:0]         req_address         = '0;
   logic [31:0]         req_transfer_size   = '0;
   logic                csr_write_enable    = 1'b0;
   logic                csr_write_data      = 1'b0;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic                rsp_cacheable_dest;
   logic                rsp_complete;
   logic [31:0]         rsp_missing_address;
   logic [PAY_W-1:0]    rsp_missing_size;

   always #1 clock = ~clock;

   received_chunk_tracker #(
      .MAP_ENTRIES(ENTRIES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_address        (req_address),
      .req_transfer_size  (req_transfer_size),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_cacheable_dest (rsp_cacheable_dest),
      .rsp_complete       (rsp_complete),
      .rsp_missing_address(rsp_missing_address),
      .rsp_missing_size   (rsp_missing_size)
   );

   // ------------------------------------------------------------------------
   // tracker state as the bench sees it
   // ------------------------------------------------------------------------
   bit [ENTRIES-1:0] seen_map    = '0;   // one bit per chunk slot
   logic [31:0]      xfer_base   = '0;
   logic [31:0]      xfer_total  = '0;
   logic             legacy_mode = 1'b0; // live copy of the mode register
   logic [31:0]      next_entry  = '0;   // next in-order chunk the generator sends

   chunk_rsp_type    awaited_reports [$];
   int unsigned      fault_count     = 0;
   int unsigned      quiet_cycles    = 0;
   int unsigned      req_count       = 0;
   int unsigned      start_count     = 0;
   int unsigned      complete_count  = 0;
   int unsigned      range_count     = 0;

   function automatic logic [31:0] chunk_bytes();
      return legacy_mode ? 32'(PAY_OLD) : 32'(PAY_NEW);
   endfunction

   // slots that the current transfer spans, rounded up
   function automatic logic [31:0] entries_needed();
      logic [63:0] pay;
      pay = 64'(chunk_bytes());
      return 32'((64'(xfer_total) + pay - 64'd1) / pay);
   endfunction

   // applies one accepted request to the bench state, returns its report
   function automatic chunk_rsp_type track_item(input chunk_req_type r);
      chunk_rsp_type res;
      logic [31:0]   pay;
      logic [31:0]   idx;
      logic [31:0]   need;
      logic [31:0]   i;
      logic [31:0]   off;
      logic [31:0]   left;
      res = '0;
      pay = chunk_bytes();
      case (r.op)
         OP_START: begin
            // legacy cap is map size times 1 KB, checked on top of the hard cap
            if (r.size > 32'(SIZE_CAP) ||
                (legacy_mode && 64'(r.size) > 64'(ENTRIES) * 64'(PAY_OLD))) begin
               res.status = ST_TOO_BIG;
            end else begin
               xfer_base     = r.addr;
               xfer_total    = r.size;
               seen_map      = '0;
               res.cacheable = r.addr[31:29] != NOCACHE_RGN_LO &&
                               r.addr[31:29] != NOCACHE_RGN_HI;
            end
         end
         OP_CHUNK: begin
            // offset wraps, so an address just below the base lands out of range
            idx = (r.addr - xfer_base) / pay;
            if (idx >= 32'(ENTRIES)) begin
               res.status = ST_RANGE;
            end else begin
               seen_map[idx] = 1'b1;
            end
         end
         OP_DONE: begin
            need = entries_needed();
            i    = '0;
            while (i < need && i < 32'(ENTRIES) && seen_map[i]) i++;
            if (i == need) begin
               res.complete = 1'b1;
            end else begin
               off           = i * pay;
               left          = xfer_total - off;
               res.miss_addr = xfer_base + off;
               res.miss_size = PAY_W'(left < pay ? left : pay);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // random request, mostly chunks of the live transfer in order, some noise
   function automatic chunk_req_type make_request();
      chunk_req_type r;
      logic [31:0]   pay;
      logic [31:0]   need;
      logic [31:0]   k;
      int unsigned   pick;
      int unsigned   size_pick;
      r.op   = OP_CHUNK;
      r.addr = $urandom();
      r.size = $urandom();
      pay    = chunk_bytes();
      need   = entries_needed();
      pick   = $urandom_range(99);
      if (pick < 5) begin
         r.op       = OP_START;
         next_entry = '0;
         size_pick  = $urandom_range(99);
         // mostly short transfers so they can finish, a few at the cap
         if (size_pick < 50)      r.size = $urandom_range(12000);
         else if (size_pick < 80) r.size = $urandom_range(60000);
         else if (size_pick < 90) r.size = $urandom_range(SIZE_CAP);
         else if (size_pick < 95) r.size = 32'(SIZE_CAP) + $urandom_range(1);
      end else if (pick < 17) begin
         r.op = OP_DONE;
      end else if (pick < 21) begin
         r.op = OP_NONE;
      end else if (pick >= 29) begin
         // chunk of the live transfer, random byte inside the chunk
         if (need == 0) begin
            k = $urandom_range(3);
         end else if (pick < 35 || next_entry >= need) begin
            k = $urandom_range(need - 1);
         end else begin
            // now and then skip one so a hole stays open
            k          = next_entry;
            next_entry = next_entry + (($urandom_range(9) == 0) ? 32'd2 : 32'd1);
         end
         r.addr = xfer_base + k * pay + $urandom_range(pay - 1);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side: idle at random, hold start until a transfer happens
   // ------------------------------------------------------------------------
   task automatic send_request(input chunk_req_type r, input int unsigned idle_pct,
                               output chunk_rsp_type predicted);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_operation     <= r.op;
      req_address       <= r.addr;
      req_transfer_size <= r.size;
      do @(posedge clock); while (busy);
      // transfer at this edge; start stays up for a back-to-back request
      predicted = track_item(r);
      req_count++;
      if (r.op == OP_START && predicted.status == ST_OK) start_count++;
      if (predicted.complete) complete_count++;
      if (predicted.status == ST_RANGE) range_count++;
   endtask

   // mode register changes only once every report is back and busy is low
   task automatic write_mode(input logic legacy);
      while (awaited_reports.size() != 0 || busy) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= legacy;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      legacy_mode       = legacy;
   endtask

   // ------------------------------------------------------------------------
   // directed table, run in 1440-byte mode right after reset
   // ------------------------------------------------------------------------
   dir_row_type dir_rows [DIR_ROWS] = '{
      // nothing started: zero size counts as complete
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b1, 32'h0, 11'd0}},
      // unused operation with every input bit set
      '{'{OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0},
      // size limit
      '{'{OP_START, BASE, 32'hFFFF_FFFF}, 1'b1, '{ST_TOO_BIG, 1'b0, 1'b0, 32'h0, 11'd0}},
      '{'{OP_START, BASE, 32'(SIZE_CAP + 1)}, 1'b1,
        '{ST_TOO_BIG, 1'b0, 1'b0, 32'h0, 11'd0}},
      // uncached regions, then a cached one
      '{'{OP_START, 32'hA000_0000, 32'd4000}, 1'b1, '0},
      '{'{OP_START, 32'hE000_0000, 32'd4000}, 1'b1, '0},
      '{'{OP_START, BASE, 32'd4000}, 1'b1, '{ST_OK, 1'b1, 1'b0, 32'h0, 11'd0}},
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b0, BASE, 11'(PAY_NEW)}},
      '{'{OP_CHUNK, BASE + 32'd1439, 32'h0}, 1'b0, '0},
      '{'{OP_CHUNK, BASE + 32'd1440, 32'h0}, 1'b0, '0},
      // last chunk clipped to the remainder
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b0, BASE + 32'd2880, 11'd1120}},
      // chunk out of map: below the base, and one past the last slot
      '{'{OP_CHUNK, BASE - 32'd1, 32'h0}, 1'b1, '{ST_RANGE, 1'b0, 1'b0, 32'h0, 11'd0}},
      '{'{OP_CHUNK, BASE + 32'(ENTRIES * PAY_NEW), 32'h0}, 1'b1,
        '{ST_RANGE, 1'b0, 1'b0, 32'h0, 11'd0}},
      '{'{OP_CHUNK, BASE + 32'(ENTRIES * PAY_NEW - 1), 32'h0}, 1'b0, '0},
      '{'{OP_CHUNK, BASE + 32'd2880, 32'h0}, 1'b0, '0},
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b1, 32'h0, 11'd0}},
      // largest transfer at the top address, missing address wraps
      '{'{OP_START, 32'hFFFF_FFFF, 32'(SIZE_CAP)}, 1'b1, '0},
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'hFFFF_FFFF, 11'(PAY_NEW)}},
      '{'{OP_CHUNK, 32'h0, 32'h0}, 1'b0, '0},
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'h0000_059F, 11'(PAY_NEW)}},
      // empty transfer is complete at once
      '{'{OP_START, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b1, 1'b0, 32'h0, 11'd0}},
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b1, 32'h0, 11'd0}},
      '{'{OP_CHUNK, 32'h0, 32'h0}, 1'b0, '0},
      // one-byte transfer
      '{'{OP_START, 32'hC000_0000, 32'd1}, 1'b1, '{ST_OK, 1'b1, 1'b0, 32'h0, 11'd0}},
      '{'{OP_DONE, 32'h0, 32'h0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 32'hC000_0000, 11'd1}}
   };

   // ------------------------------------------------------------------------
   // stimulus: reset, directed table, six random phases, drain
   // ------------------------------------------------------------------------
   initial begin : stimulus
      chunk_rsp_type got;
      chunk_req_type r;
      int unsigned   idle_share [3];
      idle_share = '{19, 49, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // block runs its clearing pass now, busy holds the first request off
      foreach (dir_rows[n]) begin
         send_request(dir_rows[n].req, idle_share[0], got);
         awaited_reports.push_back(dir_rows[n].typed ? dir_rows[n].rsp : got);
      end
      start <= 1'b0;
      // each idling pattern once in each payload mode
      for (int ph = 0; ph < 6; ph++) begin
         write_mode(ph % 2 == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = make_request();
            send_request(r, idle_share[ph / 2], got);
            awaited_reports.push_back(got);
         end
         start <= 1'b0;
      end
      while (awaited_reports.size() != 0) @(posedge clock);
      // any stray report after the last one is caught here
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb_top: %0d requests over both payload modes, %0d transfers begun,",
               req_count, start_count);
      $display("tb_top: %0d complete reports, %0d out-of-map chunks",
               complete_count, range_count);
      if (fault_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // report side: every strobe is a transfer, compared with the oldest entry
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_reports
      chunk_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_reports.size() == 0) begin
            $error("report with nothing outstanding");
            fault_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fault_count++;
            end
            if (rsp_cacheable_dest !== want.cacheable) begin
               $error("cacheable_dest: expected %0d, got %0d", want.cacheable,
                      rsp_cacheable_dest);
               fault_count++;
            end
            if (rsp_complete !== want.complete) begin
               $error("complete: expected %0d, got %0d", want.complete, rsp_complete);
               fault_count++;
            end
            if (rsp_missing_address !== want.miss_addr) begin
               $error("missing_address: expected %h, got %h", want.miss_addr,
                      rsp_missing_address);
               fault_count++;
            end
            if (rsp_missing_size !== want.miss_size) begin
               $error("missing_size: expected %0d, got %0d", want.miss_size,
                      rsp_missing_size);
               fault_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any transfer on either side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/rct_pkg.sv
src/rct_div.sv
src/rct_find.sv
src/received_chunk_tracker.sv
tb/tb_top.sv
